// ===== hdl/ffa_pkg.sv =====
`timescale 1ns / 1ps

package ffa_pkg;

    // fixed field widths
    localparam int FIELD_W = 15;
    localparam int COST_W  = 17;

    // default sizing
    localparam int DEF_POOL_BYTES   = 16384;
    localparam int DEF_HEADER_BYTES = 16;
    localparam int DEF_MAX_BLOCKS   = 64;

    // request kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // one block table entry
    typedef struct packed {
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] length;
        logic               free;
    } entry_t;

endpackage

// ===== hdl/ffa_if.sv =====
`timescale 1ns / 1ps

// request channel
interface ffa_req_if;
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic [ffa_pkg::FIELD_W-1:0] request_size;
    logic [ffa_pkg::FIELD_W-1:0] address;

    modport source (output valid, kind, request_size, address, input ready);
    modport sink (input valid, kind, request_size, address, output ready);
endinterface

// response channel
interface ffa_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       ok;
    logic [ffa_pkg::FIELD_W-1:0] payload_offset;
    logic [ffa_pkg::FIELD_W-1:0] free_bytes;
    logic                       is_clean;

    modport source (output valid, ok, payload_offset, free_bytes, is_clean, input ready);
    modport sink (input valid, ok, payload_offset, free_bytes, is_clean, output ready);
endinterface

// ===== hdl/ffa_table.sv =====
`timescale 1ns / 1ps

module ffa_table #(
    parameter int POOL_BYTES = ffa_pkg::DEF_POOL_BYTES,
    parameter int MAX_BLOCKS = ffa_pkg::DEF_MAX_BLOCKS,
    parameter int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [IDX_W-1:0]    rd_addr,
    output ffa_pkg::entry_t     rd_data,
    input  logic                wr_en,
    input  logic [IDX_W-1:0]    wr_addr,
    input  ffa_pkg::entry_t     wr_data
);
    import ffa_pkg::*;

    entry_t mem [MAX_BLOCKS];
    entry_t mem_q_reg;
    logic   e0_valid_reg;
    logic   use_init_reg;
    entry_t init_entry;

    // entry 0 covers the whole pool until first written
    always_comb
    begin
        init_entry.start  = '0;
        init_entry.length = FIELD_W'(POOL_BYTES);
        init_entry.free   = 1'b1;
    end

    // storage, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        mem_q_reg <= mem[rd_addr];
    end

    // entry 0 valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e0_valid_reg <= 1'b0;
            use_init_reg <= 1'b0;
        end
        else
        begin
            if (wr_en && wr_addr == '0)
            begin
                e0_valid_reg <= 1'b1;
            end
            use_init_reg <= (rd_addr == '0) && !e0_valid_reg;
        end
    end

    assign rd_data = use_init_reg ? init_entry : mem_q_reg;

endmodule

// ===== hdl/ffa_ctrl.sv =====
`timescale 1ns / 1ps

module ffa_ctrl #(
    parameter int POOL_BYTES   = ffa_pkg::DEF_POOL_BYTES,
    parameter int HEADER_BYTES = ffa_pkg::DEF_HEADER_BYTES,
    parameter int MAX_BLOCKS   = ffa_pkg::DEF_MAX_BLOCKS,
    parameter int IDX_W        = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    ffa_req_if.sink           req,
    ffa_rsp_if.source         rsp,
    output logic [IDX_W-1:0]  rd_addr,
    input  ffa_pkg::entry_t   rd_data,
    output logic              wr_en,
    output logic [IDX_W-1:0]  wr_addr,
    output ffa_pkg::entry_t   wr_data
);
    import ffa_pkg::*;

    localparam int CNT_W = $clog2(MAX_BLOCKS + 2);
    localparam logic [15:0] ROUND_ADD = 16'h0003;
    localparam logic [15:0] ROUND_MASK = ~16'h0003;

    typedef enum logic [4:0] {
        S_IDLE, S_A_RD, S_A_CHK, S_UP_RD, S_UP_WR, S_A_TAIL, S_A_HEAD,
        S_F_RD, S_F_CHK, S_F_RDN, S_F_GETN, S_F_RDP, S_F_GETP, S_F_WR,
        S_DN_RD, S_DN_WR, S_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [CNT_W-1:0]   src_reg, src_next;
    logic [CNT_W-1:0]   dst_reg, dst_next;
    logic [CNT_W-1:0]   lim_reg, lim_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [FIELD_W-1:0] avail_reg, avail_next;
    logic [COST_W-1:0]  cost_reg, cost_next;
    logic [FIELD_W-1:0] target_reg, target_next;
    entry_t             cur_reg, cur_next;
    entry_t             nxt_reg, nxt_next;
    entry_t             prv_reg, prv_next;
    logic               res_ok_reg, res_ok_next;
    logic [FIELD_W-1:0] res_pay_reg, res_pay_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_ok_reg, out_ok_next;
    logic [FIELD_W-1:0] out_pay_reg, out_pay_next;
    logic [FIELD_W-1:0] out_free_reg, out_free_next;
    logic               out_clean_reg, out_clean_next;

    logic [15:0]        rounded;
    logic               a_hit;
    logic [FIELD_W-1:0] merged_len;
    logic [CNT_W-1:0]   merge_pos;
    logic [CNT_W-1:0]   removed;

    // size rounding up to a multiple of four
    always_comb
    begin
        rounded = ({1'b0, req.request_size} + ROUND_ADD) & ROUND_MASK;
    end

    assign a_hit = rd_data.free && ({2'b00, rd_data.length} > cost_reg);

    // merged free block
    always_comb
    begin
        merged_len = cur_reg.length + (prv_reg.free ? prv_reg.length : '0)
                   + (nxt_reg.free ? nxt_reg.length : '0);
        merge_pos  = prv_reg.free ? idx_reg - CNT_W'(1) : idx_reg;
        removed    = CNT_W'(prv_reg.free) + CNT_W'(nxt_reg.free);
    end

    // table read address
    always_comb
    begin
        case (state_reg)
            S_UP_RD: rd_addr = src_reg[IDX_W-1:0];
            S_DN_RD: rd_addr = src_reg[IDX_W-1:0];
            S_F_RDN: rd_addr = IDX_W'(idx_reg + CNT_W'(1));
            S_F_RDP: rd_addr = IDX_W'(idx_reg - CNT_W'(1));
            default: rd_addr = idx_reg[IDX_W-1:0];
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        lim_next       = lim_reg;
        count_next     = count_reg;
        avail_next     = avail_reg;
        cost_next      = cost_reg;
        target_next    = target_reg;
        cur_next       = cur_reg;
        nxt_next       = nxt_reg;
        prv_next       = prv_reg;
        res_ok_next    = res_ok_reg;
        res_pay_next   = res_pay_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_ok_next    = out_ok_reg;
        out_pay_next   = out_pay_reg;
        out_free_next  = out_free_reg;
        out_clean_next = out_clean_reg;
        wr_en          = 1'b0;
        wr_addr        = idx_reg[IDX_W-1:0];
        wr_data        = rd_data;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    idx_next     = '0;
                    res_ok_next  = 1'b0;
                    res_pay_next = '0;
                    cost_next    = {1'b0, rounded} + COST_W'(2 * HEADER_BYTES);
                    target_next  = req.address - FIELD_W'(HEADER_BYTES);
                    if (req.kind == KIND_ALLOC)
                    begin
                        if (req.request_size == '0 ||
                            count_reg >= CNT_W'(MAX_BLOCKS))
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_A_RD;
                        end
                    end
                    else
                    begin
                        if (req.address < FIELD_W'(HEADER_BYTES))
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_F_RD;
                        end
                    end
                end
            end
            S_A_RD:
            begin
                state_next = S_A_CHK;
            end
            S_A_CHK:
            begin
                if (a_hit)
                begin
                    cur_next = rd_data;
                    if (count_reg - CNT_W'(1) > idx_reg)
                    begin
                        src_next   = count_reg - CNT_W'(1);
                        state_next = S_UP_RD;
                    end
                    else
                    begin
                        state_next = S_A_TAIL;
                    end
                end
                else if (idx_reg + CNT_W'(1) >= count_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = S_A_RD;
                end
            end
            S_UP_RD:
            begin
                state_next = S_UP_WR;
            end
            S_UP_WR:
            begin
                // move one entry up to open the slot after the split block
                wr_en   = 1'b1;
                wr_addr = IDX_W'(src_reg + CNT_W'(1));
                wr_data = rd_data;
                if (src_reg == idx_reg + CNT_W'(1))
                begin
                    state_next = S_A_TAIL;
                end
                else
                begin
                    src_next   = src_reg - CNT_W'(1);
                    state_next = S_UP_RD;
                end
            end
            S_A_TAIL:
            begin
                wr_en          = 1'b1;
                wr_addr        = IDX_W'(idx_reg + CNT_W'(1));
                wr_data.start  = cur_reg.start + cost_reg[FIELD_W-1:0];
                wr_data.length = cur_reg.length - cost_reg[FIELD_W-1:0];
                wr_data.free   = 1'b1;
                state_next     = S_A_HEAD;
            end
            S_A_HEAD:
            begin
                wr_en          = 1'b1;
                wr_addr        = idx_reg[IDX_W-1:0];
                wr_data.start  = cur_reg.start;
                wr_data.length = cost_reg[FIELD_W-1:0];
                wr_data.free   = 1'b0;
                count_next     = count_reg + CNT_W'(1);
                avail_next     = avail_reg - cost_reg[FIELD_W-1:0];
                res_ok_next    = 1'b1;
                res_pay_next   = cur_reg.start + FIELD_W'(HEADER_BYTES);
                state_next     = S_DONE;
            end
            S_F_RD:
            begin
                state_next = S_F_CHK;
            end
            S_F_CHK:
            begin
                if (rd_data.start == target_reg)
                begin
                    if (rd_data.free)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cur_next      = rd_data;
                        nxt_next.free = 1'b0;
                        prv_next.free = 1'b0;
                        avail_next    = avail_reg + rd_data.length;
                        if (idx_reg + CNT_W'(1) < count_reg)
                        begin
                            state_next = S_F_RDN;
                        end
                        else if (idx_reg != '0)
                        begin
                            state_next = S_F_RDP;
                        end
                        else
                        begin
                            state_next = S_F_WR;
                        end
                    end
                end
                else if (idx_reg + CNT_W'(1) >= count_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = S_F_RD;
                end
            end
            S_F_RDN:
            begin
                state_next = S_F_GETN;
            end
            S_F_GETN:
            begin
                nxt_next   = rd_data;
                state_next = (idx_reg != '0) ? S_F_RDP : S_F_WR;
            end
            S_F_RDP:
            begin
                state_next = S_F_GETP;
            end
            S_F_GETP:
            begin
                prv_next   = rd_data;
                state_next = S_F_WR;
            end
            S_F_WR:
            begin
                // write the merged free block, then close the gap
                wr_en          = 1'b1;
                wr_addr        = merge_pos[IDX_W-1:0];
                wr_data.start  = prv_reg.free ? prv_reg.start : cur_reg.start;
                wr_data.length = merged_len;
                wr_data.free   = 1'b1;
                src_next       = idx_reg + CNT_W'(1) + CNT_W'(nxt_reg.free);
                dst_next       = merge_pos + CNT_W'(1);
                lim_next       = count_reg;
                count_next     = count_reg - removed;
                res_ok_next    = 1'b1;
                if (removed != '0 &&
                    idx_reg + CNT_W'(1) + CNT_W'(nxt_reg.free) < count_reg)
                begin
                    state_next = S_DN_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DN_RD:
            begin
                state_next = S_DN_WR;
            end
            S_DN_WR:
            begin
                wr_en    = 1'b1;
                wr_addr  = dst_reg[IDX_W-1:0];
                wr_data  = rd_data;
                src_next = src_reg + CNT_W'(1);
                dst_next = dst_reg + CNT_W'(1);
                if (src_reg + CNT_W'(1) < lim_reg)
                begin
                    state_next = S_DN_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = res_ok_reg;
                    out_pay_next   = res_pay_reg;
                    out_free_next  = avail_reg;
                    out_clean_next = (avail_reg == FIELD_W'(POOL_BYTES));
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            src_reg       <= '0;
            dst_reg       <= '0;
            lim_reg       <= '0;
            count_reg     <= CNT_W'(1);
            avail_reg     <= FIELD_W'(POOL_BYTES);
            cost_reg      <= '0;
            target_reg    <= '0;
            cur_reg       <= '0;
            nxt_reg       <= '0;
            prv_reg       <= '0;
            res_ok_reg    <= 1'b0;
            res_pay_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_ok_reg    <= 1'b0;
            out_pay_reg   <= '0;
            out_free_reg  <= '0;
            out_clean_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            src_reg       <= src_next;
            dst_reg       <= dst_next;
            lim_reg       <= lim_next;
            count_reg     <= count_next;
            avail_reg     <= avail_next;
            cost_reg      <= cost_next;
            target_reg    <= target_next;
            cur_reg       <= cur_next;
            nxt_reg       <= nxt_next;
            prv_reg       <= prv_next;
            res_ok_reg    <= res_ok_next;
            res_pay_reg   <= res_pay_next;
            out_valid_reg <= out_valid_next;
            out_ok_reg    <= out_ok_next;
            out_pay_reg   <= out_pay_next;
            out_free_reg  <= out_free_next;
            out_clean_reg <= out_clean_next;
        end
    end

    assign req.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = out_valid_reg;
    assign rsp.ok             = out_ok_reg;
    assign rsp.payload_offset = out_pay_reg;
    assign rsp.free_bytes     = out_free_reg;
    assign rsp.is_clean       = out_clean_reg;

    // block count stays within the table
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg >= CNT_W'(1) && count_reg <= CNT_W'(MAX_BLOCKS))
        else $error("block count out of range");

    // available bytes never exceed the pool
    a_avail_range: assert property (@(posedge clk) disable iff (!rst_n)
        avail_reg <= FIELD_W'(POOL_BYTES))
        else $error("available bytes exceed pool");

    // a split only happens with a spare table entry
    a_split_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_A_CHK && a_hit) |-> count_reg < CNT_W'(MAX_BLOCKS))
        else $error("split with full table");

    // a completed item leaves a response beat behind
    a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && state_next == S_IDLE) |=> out_valid_reg)
        else $error("response beat lost");

endmodule

// ===== hdl/first_fit_block_allocator.sv =====
`timescale 1ns / 1ps

// First-fit allocator over one byte pool, block table held in one memory.
// req channel: one beat per operation; kind selects allocate or free,
// request_size is used by allocate, address (payload offset) by free.
// rsp channel: exactly one beat per request beat, in order, carrying ok,
// payload_offset, free_bytes and is_clean after the operation.
// One request is in work at a time; req.ready is high only between items.
// Each table entry touched takes a registered memory read, then a check or
// write back; the table has one read port and one write port.
// Allocate: scan entries up to the hit, move entries up to open a slot,
// then write the tail and the head of the split block.
// Free: scan entries, read the next and previous neighbors if present,
// write the merged block, then move entries down to close the gap.
// The result sits in an output register; the next request is accepted
// while it waits, but an item's result is held back until rsp is taken.
// Reset: one free block covers the whole pool; no clearing pass is run.
module first_fit_block_allocator #(
    parameter int POOL_BYTES   = ffa_pkg::DEF_POOL_BYTES,
    parameter int HEADER_BYTES = ffa_pkg::DEF_HEADER_BYTES,
    parameter int MAX_BLOCKS   = ffa_pkg::DEF_MAX_BLOCKS
) (
    input  logic      clk,
    input  logic      rst_n,
    ffa_req_if.sink   req,
    ffa_rsp_if.source rsp
);
    import ffa_pkg::*;

    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic             wr_en;
    entry_t           rd_data;
    entry_t           wr_data;

    // block table
    ffa_table #(
        .POOL_BYTES (POOL_BYTES),
        .MAX_BLOCKS (MAX_BLOCKS),
        .IDX_W      (IDX_W)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // sequencer
    ffa_ctrl #(
        .POOL_BYTES   (POOL_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .MAX_BLOCKS   (MAX_BLOCKS),
        .IDX_W        (IDX_W)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

endmodule
